[rtl/sdvg_pkg.sv]
package sdvg_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 11;
    localparam int RADIUS_W   = 16;
    localparam int IDX_W      = 30;
    localparam int DIST_W     = 20;
    localparam int RADIUS_FRAC_BITS = 16;

    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 11'd64;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd16384;

    localparam int DIST_MAX = 524287;
    localparam int DIST_MIN = -524288;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_RADIUS = 2'd3
    } t_reg_idx;

endpackage

[rtl/sdvg_regs.sv]
module sdvg_regs #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sdvg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sdvg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sdvg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [$clog2(MAX_DIM):0]            o_eff_x,
    output logic [$clog2(MAX_DIM):0]            o_eff_y,
    output logic [$clog2(MAX_DIM):0]            o_eff_z,
    output logic [sdvg_pkg::RADIUS_W-1:0]       o_radius,
    output logic                                o_scan_clear
);

    localparam int EW = $clog2(MAX_DIM) + 1;

    logic [sdvg_pkg::SIZE_W-1:0]   r_size_x;
    logic [sdvg_pkg::SIZE_W-1:0]   r_size_y;
    logic [sdvg_pkg::SIZE_W-1:0]   r_size_z;
    logic [sdvg_pkg::RADIUS_W-1:0] r_radius;
    logic                          wr_en;
    sdvg_pkg::t_reg_idx            reg_sel;

    function automatic logic [EW-1:0] eff_size(input logic [sdvg_pkg::SIZE_W-1:0] raw);
        logic [EW-1:0] res;
        if (raw == '0) begin
            res = EW'(1);
        end else if (32'(raw) > MAX_DIM) begin
            res = EW'(MAX_DIM);
        end else begin
            res = EW'(raw);
        end
        return res;
    endfunction

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = sdvg_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= sdvg_pkg::SIZE_RESET;
            r_size_y <= sdvg_pkg::SIZE_RESET;
            r_size_z <= sdvg_pkg::SIZE_RESET;
            r_radius <= sdvg_pkg::RADIUS_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                sdvg_pkg::REG_SIZE_X: r_size_x <= pwdata[sdvg_pkg::SIZE_W-1:0];
                sdvg_pkg::REG_SIZE_Y: r_size_y <= pwdata[sdvg_pkg::SIZE_W-1:0];
                sdvg_pkg::REG_SIZE_Z: r_size_z <= pwdata[sdvg_pkg::SIZE_W-1:0];
                sdvg_pkg::REG_RADIUS: r_radius <= pwdata[sdvg_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            sdvg_pkg::REG_SIZE_X: prdata = sdvg_pkg::CFG_DATA_W'(r_size_x);
            sdvg_pkg::REG_SIZE_Y: prdata = sdvg_pkg::CFG_DATA_W'(r_size_y);
            sdvg_pkg::REG_SIZE_Z: prdata = sdvg_pkg::CFG_DATA_W'(r_size_z);
            sdvg_pkg::REG_RADIUS: prdata = sdvg_pkg::CFG_DATA_W'(r_radius);
            default:              prdata = '0;
        endcase
    end

    assign o_scan_clear = wr_en && (reg_sel != sdvg_pkg::REG_RADIUS);
    assign o_eff_x  = eff_size(r_size_x);
    assign o_eff_y  = eff_size(r_size_y);
    assign o_eff_z  = eff_size(r_size_z);
    assign o_radius = r_radius;

endmodule

[rtl/sdvg_front.sv]
module sdvg_front #(
    parameter int MAX_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_restart,
    input  logic                            i_scan_clear,
    input  logic [$clog2(MAX_DIM):0]        i_eff_x,
    input  logic [$clog2(MAX_DIM):0]        i_eff_y,
    input  logic [$clog2(MAX_DIM):0]        i_eff_z,
    output logic [sdvg_pkg::IDX_W-1:0]      o_idx,
    output logic [2*$clog2(MAX_DIM)+1:0]    o_s2,
    output logic                            o_last
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = CW + 1;
    localparam int SW = 2 * CW + 2;

    logic [CW-1:0]             r_x, r_y, r_z;
    logic [sdvg_pkg::IDX_W-1:0] r_idx;
    logic [CW-1:0]             cur_x, cur_y, cur_z;
    logic [CW-1:0]             n_x, n_y, n_z;
    logic [sdvg_pkg::IDX_W-1:0] n_idx;
    logic                      end_x, end_y, end_z;
    logic [CW-1:0]             a_x, a_y, a_z;
    logic [2*CW-1:0]           sq_x, sq_y, sq_z;

    function automatic logic [CW-1:0] abs_off(input logic [CW-1:0] c, input logic [EW-1:0] n);
        logic signed [CW+1:0] d;
        logic signed [CW+1:0] a;
        d = $signed({1'b0, c, 1'b0}) - $signed({1'b0, n - EW'(1)});
        a = d[CW+1] ? -d : d;
        return a[CW-1:0];
    endfunction

    always_comb begin
        cur_x = i_restart ? '0 : r_x;
        cur_y = i_restart ? '0 : r_y;
        cur_z = i_restart ? '0 : r_z;
        o_idx = i_restart ? '0 : r_idx;

        end_x = EW'(cur_x) >= i_eff_x - EW'(1);
        end_y = EW'(cur_y) >= i_eff_y - EW'(1);
        end_z = EW'(cur_z) >= i_eff_z - EW'(1);
        o_last = end_x && end_y && end_z;

        a_x  = abs_off(cur_x, i_eff_x);
        a_y  = abs_off(cur_y, i_eff_y);
        a_z  = abs_off(cur_z, i_eff_z);
        sq_x = (2*CW)'(a_x) * (2*CW)'(a_x);
        sq_y = (2*CW)'(a_y) * (2*CW)'(a_y);
        sq_z = (2*CW)'(a_z) * (2*CW)'(a_z);
        o_s2 = SW'(sq_x) + SW'(sq_y) + SW'(sq_z);

        n_x   = end_x ? '0 : cur_x + CW'(1);
        n_y   = cur_y;
        n_z   = cur_z;
        if (end_x) begin
            n_y = end_y ? '0 : cur_y + CW'(1);
            if (end_y) begin
                n_z = end_z ? '0 : cur_z + CW'(1);
            end
        end
        n_idx = o_last ? '0 : o_idx + sdvg_pkg::IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_scan_clear) begin
            r_x   <= '0;
            r_y   <= '0;
            r_z   <= '0;
            r_idx <= '0;
        end else if (i_accept) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_idx <= n_idx;
        end
    end

endmodule

[rtl/sdvg_queue.sv]
module sdvg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (32'(r_cnt) == DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/sdvg_back.sv]
module sdvg_back #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  logic [sdvg_pkg::IDX_W-1:0]         i_q_idx,
    input  logic [2*$clog2(MAX_DIM)+1:0]       i_q_s2,
    input  logic                               i_q_last,
    output logic                               o_q_pop,
    input  logic [$clog2(MAX_DIM):0]           i_eff_x,
    input  logic [$clog2(MAX_DIM):0]           i_eff_y,
    input  logic [$clog2(MAX_DIM):0]           i_eff_z,
    input  logic [sdvg_pkg::RADIUS_W-1:0]      i_radius,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sdvg_pkg::IDX_W-1:0]         o_voxel_index,
    output logic signed [sdvg_pkg::DIST_W-1:0] o_distance,
    output logic                               o_last_voxel
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int EW    = CW + 1;
    localparam int SW    = 2 * CW + 2;
    localparam int RW    = SW / 2 + 15;
    localparam int MULW  = sdvg_pkg::RADIUS_W + EW;
    localparam int DW0   = (RW > MULW) ? RW : MULW;
    localparam int DW    = ((DW0 > sdvg_pkg::DIST_W) ? DW0 : sdvg_pkg::DIST_W) + 1;
    localparam int SH    = sdvg_pkg::RADIUS_FRAC_BITS - FRAC_BITS;
    localparam int CNT_W = $clog2(RW);
    localparam logic signed [DW-1:0] QMAX = DW'(sdvg_pkg::DIST_MAX);
    localparam logic signed [DW-1:0] QMIN = DW'(sdvg_pkg::DIST_MIN);
    localparam logic [DW-1:0] RND_HALF = (DW'(1) << SH) - DW'(1);
    localparam logic [DW-1:0] RND_FULL = DW'(1) << SH;

    typedef enum logic [1:0] {S_IDLE, S_ROOT, S_DIFF, S_OUT} t_state;

    t_state                      r_state;
    logic [SW-1:0]               r_rad;
    logic [RW+1:0]               r_rem;
    logic [RW-1:0]               r_root;
    logic [CNT_W-1:0]            r_cnt;
    logic [sdvg_pkg::IDX_W-1:0]  r_idx;
    logic                        r_last;
    logic [MULW-1:0]             r_r16;
    logic signed [DW-1:0]        r_diff;
    logic                        r_exact;

    logic [EW-1:0]               m_xy, m_min;
    logic [RW+3:0]               rem_sh, trial, rem_sub;
    logic                        ge;
    logic signed [DW-1:0]        q_sum, q_sh, q_sat;
    logic                        out_free;

    always_comb begin
        m_xy    = (i_eff_x < i_eff_y) ? i_eff_x : i_eff_y;
        m_min   = (m_xy < i_eff_z) ? m_xy : i_eff_z;
        rem_sh  = {r_rem, r_rad[SW-1:SW-2]};
        trial   = {2'b00, r_root, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;

        q_sum = r_diff + $signed(r_diff[DW-1] ? (r_exact ? RND_HALF : RND_FULL) : '0);
        q_sh  = q_sum >>> SH;
        if (q_sh > QMAX) begin
            q_sat = QMAX;
        end else if (q_sh < QMIN) begin
            q_sat = QMIN;
        end else begin
            q_sat = q_sh;
        end

        out_free = !o_valid || !i_stall;
        o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    end

    always_ff @(posedge i_clk) begin
        r_r16 <= MULW'(i_radius) * MULW'(m_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (r_state != S_OUT && o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_rad   <= i_q_s2;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= CNT_W'(RW - 1);
                        r_idx   <= i_q_idx;
                        r_last  <= i_q_last;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_rem  <= ge ? rem_sub[RW+1:0] : rem_sh[RW+1:0];
                    r_root <= {r_root[RW-2:0], ge};
                    r_rad  <= {r_rad[SW-3:0], 2'b00};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_diff  <= $signed(DW'(r_root)) - $signed(DW'(r_r16));
                    r_exact <= (r_rem == '0);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_voxel_index <= r_idx;
                        o_distance    <= q_sat[sdvg_pkg::DIST_W-1:0];
                        o_last_voxel  <= r_last;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/sphere_distance_volume_generator_core.sv]
// sphere signed distance volume generator
// input channel: i_valid / o_stall, payload i_restart; each transaction
// produces exactly one voxel, restart returns the scan to voxel 0 first
// output channel: o_valid / i_stall, payload o_voxel_index, o_distance
// (signed, FRAC_BITS fraction bits) and o_last_voxel; the scan wraps after
// the last voxel
// config over the apb-style port: size_x, size_y, size_z, radius_fraction at
// byte addresses 0, 4, 8, 12; a size write also returns the scan to voxel 0
// the front takes a transaction, squares the offsets from the centre and
// queues it (two entries); the back runs a digit-by-digit square root, one
// result bit per cycle, and pops the next voxel only after the last one has
// gone out, so that loop sets the throughput; from the queue a voxel passes
// the idle, root, diff and out states to o_valid
// a result held by i_stall stays stable while the queue keeps filling;
// o_stall rises once the queue is full
// reset (synchronous, active low) loads the default registers, empties the
// queue and starts the scan at voxel 0
module sphere_distance_volume_generator_core #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_restart,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sdvg_pkg::IDX_W-1:0]         o_voxel_index,
    output logic signed [sdvg_pkg::DIST_W-1:0] o_distance,
    output logic                               o_last_voxel,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sdvg_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sdvg_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sdvg_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = CW + 1;
    localparam int SW = 2 * CW + 2;
    localparam int QW = sdvg_pkg::IDX_W + SW + 1;

    logic [EW-1:0]                  eff_x, eff_y, eff_z;
    logic [sdvg_pkg::RADIUS_W-1:0]  radius;
    logic                           scan_clear;
    logic                           accept;
    logic [sdvg_pkg::IDX_W-1:0]     f_idx, q_idx;
    logic [SW-1:0]                  f_s2, q_s2;
    logic                           f_last, q_last;
    logic [QW-1:0]                  q_rd;
    logic                           q_full, q_empty, q_pop;

    assign accept = i_valid && !o_stall;
    assign o_stall = q_full;

    sdvg_regs #(.MAX_DIM(MAX_DIM)) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_eff_x      (eff_x),
        .o_eff_y      (eff_y),
        .o_eff_z      (eff_z),
        .o_radius     (radius),
        .o_scan_clear (scan_clear)
    );

    sdvg_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_restart    (i_restart),
        .i_scan_clear (scan_clear),
        .i_eff_x      (eff_x),
        .i_eff_y      (eff_y),
        .i_eff_z      (eff_z),
        .o_idx        (f_idx),
        .o_s2         (f_s2),
        .o_last       (f_last)
    );

    sdvg_queue #(.W(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({f_idx, f_s2, f_last}),
        .i_pop   (q_pop),
        .o_data  (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {q_idx, q_s2, q_last} = q_rd;

    sdvg_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_idx       (q_idx),
        .i_q_s2        (q_s2),
        .i_q_last      (q_last),
        .o_q_pop       (q_pop),
        .i_eff_x       (eff_x),
        .i_eff_y       (eff_y),
        .i_eff_z       (eff_z),
        .i_radius      (radius),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_voxel_index (o_voxel_index),
        .o_distance    (o_distance),
        .o_last_voxel  (o_last_voxel)
    );

endmodule

[tb/tb_top.sv]
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOL_MAX_DIM    = 1024;
    localparam int DIST_FRAC      = 8;
    localparam int ITEM_TARGET    = 1200;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [sdvg_pkg::IDX_W-1:0]         index;
        logic signed [sdvg_pkg::DIST_W-1:0] distance;
        logic                               last;
    } t_voxel;

    class sdf_scoreboard;
        logic [sdvg_pkg::SIZE_W-1:0]   size_x;
        logic [sdvg_pkg::SIZE_W-1:0]   size_y;
        logic [sdvg_pkg::SIZE_W-1:0]   size_z;
        logic [sdvg_pkg::RADIUS_W-1:0] radius;
        int                            scan_x;
        int                            scan_y;
        int                            scan_z;
        t_voxel                        voxel_expect_q[$];
        int                            err_cnt;
        int                            n_noted;
        int                            n_checked;
        int                            n_last;
        int                            n_restart;

        function new();
            size_x    = sdvg_pkg::SIZE_RESET;
            size_y    = sdvg_pkg::SIZE_RESET;
            size_z    = sdvg_pkg::SIZE_RESET;
            radius    = sdvg_pkg::RADIUS_RESET;
            scan_x    = 0;
            scan_y    = 0;
            scan_z    = 0;
            err_cnt   = 0;
            n_noted   = 0;
            n_checked = 0;
            n_last    = 0;
            n_restart = 0;
        endfunction

        function int pending();
            return voxel_expect_q.size();
        endfunction

        function void write_reg(sdvg_pkg::t_reg_idx r, logic [sdvg_pkg::CFG_DATA_W-1:0] v);
            case (r)
                sdvg_pkg::REG_SIZE_X: size_x = v[sdvg_pkg::SIZE_W-1:0];
                sdvg_pkg::REG_SIZE_Y: size_y = v[sdvg_pkg::SIZE_W-1:0];
                sdvg_pkg::REG_SIZE_Z: size_z = v[sdvg_pkg::SIZE_W-1:0];
                sdvg_pkg::REG_RADIUS: radius = v[sdvg_pkg::RADIUS_W-1:0];
                default: ;
            endcase
            if (r != sdvg_pkg::REG_RADIUS) begin
                scan_x = 0;
                scan_y = 0;
                scan_z = 0;
            end
        endfunction

        function int dim_of(logic [sdvg_pkg::SIZE_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (raw > VOL_MAX_DIM)
                return VOL_MAX_DIM;
            return int'(raw);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root = 0;
            longint unsigned bitv = 64'h1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // expected voxel for one accepted transaction, then step the scan
        function void note_voxel(bit restart);
            int              nx;
            int              ny;
            int              nz;
            int              m;
            longint          dx;
            longint          dy;
            longint          dz;
            longint          s2;
            longint unsigned big;
            longint unsigned t;
            bit              exact;
            longint          diff;
            longint          k;
            longint          q;
            longint          idx;
            bit              end_x;
            bit              end_y;
            bit              end_z;
            t_voxel          v;
            nx = dim_of(size_x);
            ny = dim_of(size_y);
            nz = dim_of(size_z);
            n_noted++;
            if (restart) begin
                n_restart++;
                scan_x = 0;
                scan_y = 0;
                scan_z = 0;
            end
            idx = (longint'(scan_z) * ny + scan_y) * nx + scan_x;
            dx = 2 * longint'(scan_x) - (longint'(nx) - 1);
            dy = 2 * longint'(scan_y) - (longint'(ny) - 1);
            dz = 2 * longint'(scan_z) - (longint'(nz) - 1);
            s2 = dx * dx + dy * dy + dz * dz;
            big = longint'(s2) << 30;
            t = int_sqrt(big);
            exact = (t * t == big);
            m = nx;
            if (ny < m)
                m = ny;
            if (nz < m)
                m = nz;
            diff = longint'(t) - longint'(radius) * m;
            if (diff >= 0) begin
                q = diff >>> (sdvg_pkg::RADIUS_FRAC_BITS - DIST_FRAC);
            end else begin
                k = exact ? diff : diff + 1;
                q = -((-k) >>> (sdvg_pkg::RADIUS_FRAC_BITS - DIST_FRAC));
            end
            if (q > sdvg_pkg::DIST_MAX)
                q = sdvg_pkg::DIST_MAX;
            if (q < sdvg_pkg::DIST_MIN)
                q = sdvg_pkg::DIST_MIN;
            end_x = (scan_x >= nx - 1);
            end_y = (scan_y >= ny - 1);
            end_z = (scan_z >= nz - 1);
            v.index    = idx[sdvg_pkg::IDX_W-1:0];
            v.distance = q[sdvg_pkg::DIST_W-1:0];
            v.last     = end_x && end_y && end_z;
            voxel_expect_q.push_back(v);
            if (!end_x) begin
                scan_x++;
            end else begin
                scan_x = 0;
                if (!end_y) begin
                    scan_y++;
                end else begin
                    scan_y = 0;
                    scan_z = end_z ? 0 : scan_z + 1;
                end
            end
        endfunction

        task report(string msg);
            err_cnt++;
            if (err_cnt <= 40)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_voxel(logic [sdvg_pkg::IDX_W-1:0] index,
                         logic signed [sdvg_pkg::DIST_W-1:0] distance, logic last);
            t_voxel e;
            if (voxel_expect_q.size() == 0) begin
                report($sformatf("voxel %0d out with no transaction pending", index));
            end else begin
                e = voxel_expect_q.pop_front();
                n_checked++;
                if (e.last)
                    n_last++;
                if (index !== e.index)
                    report($sformatf("index got %0d exp %0d", index, e.index));
                if (distance !== e.distance)
                    report($sformatf("distance at %0d got %0d exp %0d",
                                     e.index, distance, e.distance));
                if (last !== e.last)
                    report($sformatf("last flag at %0d got %0b exp %0b",
                                     e.index, last, e.last));
            end
        endtask
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic                               i_restart = 1'b0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [sdvg_pkg::IDX_W-1:0]         o_voxel_index;
    logic signed [sdvg_pkg::DIST_W-1:0] o_distance;
    logic                               o_last_voxel;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [sdvg_pkg::CFG_ADDR_W-1:0]    paddr = '0;
    logic [sdvg_pkg::CFG_DATA_W-1:0]    pwdata = '0;
    logic [sdvg_pkg::CFG_DATA_W-1:0]    prdata;
    logic                               pready;

    sdf_scoreboard sb;
    int            idle_cycles = 0;
    int            n_setups = 0;
    bit            pressure_req = 1'b0;
    bit            pressure_done = 1'b0;

    sphere_distance_volume_generator_core #(
        .MAX_DIM   (VOL_MAX_DIM),
        .FRAC_BITS (DIST_FRAC)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_voxel_index (o_voxel_index),
        .o_distance    (o_distance),
        .o_last_voxel  (o_last_voxel),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [sdvg_pkg::SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return sdvg_pkg::SIZE_W'($urandom_range(1, 6));
        if (r < 85)
            return sdvg_pkg::SIZE_W'($urandom_range(7, 16));
        if (r < 90)
            return '0;
        if (r < 94)
            return sdvg_pkg::SIZE_W'(VOL_MAX_DIM);
        if (r < 97)
            return sdvg_pkg::SIZE_W'(2047);
        return sdvg_pkg::SIZE_W'($urandom_range(17, 2047));
    endfunction

    function automatic logic [sdvg_pkg::RADIUS_W-1:0] pick_radius();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return 16'hffff;
        return sdvg_pkg::RADIUS_W'($urandom_range(0, 65535));
    endfunction

    task automatic write_cfg(input sdvg_pkg::t_reg_idx r,
                             input logic [sdvg_pkg::CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(r, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_volume(input int sx, input int sy, input int sz, input int rad);
        write_cfg(sdvg_pkg::REG_SIZE_X, sx);
        write_cfg(sdvg_pkg::REG_SIZE_Y, sy);
        write_cfg(sdvg_pkg::REG_SIZE_Z, sz);
        write_cfg(sdvg_pkg::REG_RADIUS, rad);
        n_setups++;
    endtask

    task automatic push_voxel(input bit restart, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_voxel(restart);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_voxel(o_voxel_index, o_distance, o_last_voxel);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side: free runs, short and long stalls, one long hold-off on request
    initial begin
        int run_len;
        int stall_len;
        forever begin
            run_len = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 8);
            repeat (run_len) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            stall_len = idle_len();
            repeat (stall_len) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            if (pressure_req && !pressure_done) begin
                pressure_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    initial begin
        int  phase;
        int  phase_items;
        bit  no_gap;
        bit  wrote;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset volume, restart mid-stream
        for (int i = 0; i < 6; i++)
            push_voxel(i == 3, 0);
        drain();

        // single-voxel volume, zero radius
        load_volume(1, 1, 1, 0);
        for (int i = 0; i < 3; i++)
            push_voxel(1'b0, i);
        drain();

        // zero size and oversize clamp, full radius
        load_volume(0, 2047, 0, 65535);
        for (int i = 0; i < 4; i++)
            push_voxel(i == 2, 0);
        drain();

        // 2x2x2 through the wrap, then a radius change keeps the scan position
        load_volume(2, 2, 2, 65535);
        for (int i = 0; i < 9; i++)
            push_voxel(1'b0, 0);
        drain();
        write_cfg(sdvg_pkg::REG_RADIUS, 32768);
        n_setups++;
        for (int i = 0; i < 3; i++)
            push_voxel(1'b0, 1);
        drain();

        phase = 0;
        while (sb.n_noted < ITEM_TARGET) begin
            wrote = 1'b0;
            if ($urandom_range(0, 1)) begin
                write_cfg(sdvg_pkg::REG_SIZE_X, sdvg_pkg::CFG_DATA_W'(pick_size()));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1)) begin
                write_cfg(sdvg_pkg::REG_SIZE_Y, sdvg_pkg::CFG_DATA_W'(pick_size()));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1)) begin
                write_cfg(sdvg_pkg::REG_SIZE_Z, sdvg_pkg::CFG_DATA_W'(pick_size()));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) || !wrote)
                write_cfg(sdvg_pkg::REG_RADIUS, sdvg_pkg::CFG_DATA_W'(pick_radius()));
            n_setups++;
            phase_items = $urandom_range(20, 80);
            no_gap = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                pressure_req = 1'b1;
                phase_items  = 80;
                no_gap       = 1'b1;
            end
            for (int i = 0; i < phase_items; i++)
                push_voxel($urandom_range(0, 19) == 0, no_gap ? 0 : idle_len());
            drain();
            phase++;
        end

        $display("run covered %0d voxels over %0d register setups", sb.n_checked, n_setups);
        $display("volume ends seen %0d, restarts %0d, long output hold %0s",
                 sb.n_last, sb.n_restart, pressure_done ? "done" : "missed");
        if (sb.err_cnt == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
